// ----- src/assert_macros.svh -----
// Assertion macros used by the top level of the retransmit timer table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Condition that must hold at every clock edge outside reset.
`define RTT_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// Implication checked at every clock edge outside reset.
`define RTT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define RTT_ASSERT_HOLDS(lbl, cond, msg)
`define RTT_ASSERT_IMPLIES(lbl, ante, cons, msg)
`endif
`endif

// ----- src/rtt_pkg.sv -----
// Types, codes and constants of the retransmit timer table.
package rtt_pkg;

  localparam int unsigned ENTRIES_DEF = 32;
  localparam logic [5:0]  RPC_RESET   = 6'd5;
  localparam logic [31:0] EXPIRY_RESET = 32'd31000;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_RECORD    = 3'd1,
    CMD_CONF_ID   = 3'd2,
    CMD_CONF_SOCK = 3'd3,
    CMD_CHECK     = 3'd4,
    CMD_CLEANUP   = 3'd5,
    CMD_CLEAR     = 3'd6,
    CMD_UNUSED    = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_STATUS  = 2'd0,
    KIND_RETX    = 2'd1,
    KIND_DROP    = 2'd2,
    KIND_SUMMARY = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RSVD      = 2'd3
  } status_e;

  // Register indexes on the configuration port.
  localparam logic REG_RPC    = 1'b0;
  localparam logic REG_EXPIRY = 1'b1;

  // One stored slot.
  typedef struct packed {
    logic [15:0] packet_id;
    logic [9:0]  socket;
    logic [31:0] sent_time;
    logic [3:0]  retries;
  } slot_ent_t;

  // One buffered entry result of a scan.
  typedef struct packed {
    kind_e       kind;
    logic [15:0] packet_id;
    logic [9:0]  socket;
    logic [3:0]  retries;
  } res_ent_t;

endpackage

// ----- src/rtt_slot_mem.sv -----
// Slot memory: one write port, one read port with registered read data.
module rtt_slot_mem #(
  parameter int unsigned ENTRIES = rtt_pkg::ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr_i,
  output rtt_pkg::slot_ent_t         rd_data_o,
  input  logic                       wr_en_i,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr_i,
  input  rtt_pkg::slot_ent_t         wr_data_i
);

  rtt_pkg::slot_ent_t mem_q [ENTRIES];
  rtt_pkg::slot_ent_t rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data valid in the cycle after the enable.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- src/rtt_result_buf.sv -----
// Result buffer: holds entry results of a scan until the command's totals are final.
module rtt_result_buf #(
  parameter int unsigned ENTRIES = rtt_pkg::ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr_i,
  input  rtt_pkg::res_ent_t          wr_data_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr_i,
  output rtt_pkg::res_ent_t          rd_data_o
);

  rtt_pkg::res_ent_t mem_q [ENTRIES];
  rtt_pkg::res_ent_t rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- src/retransmit_timer_table.sv -----
// Top level of the retransmit timer table: command sequencer, slot scan and result stream.
//
//  Channel   Signals                         Beat contents
//  s_axis    tvalid/tready/tdata/tuser       one command
//  m_axis    tvalid/tready/tdata/tuser/tlast one result, tlast on the last of a command
//  apb       psel/penable/pwrite/paddr/...   register 0 retransmits_per_check, 1 expiry_ms
//
// Tick, clear and the unused code pass through S_EMIT_RD to S_FINAL, which loads the final
// result. Record, both confirms, check and cleanup scan all ENTRIES slots through the
// single read port of the slot memory, one per cycle, and then give each retransmit or
// drop result, replayed from the result buffer, ahead of the final result.
// Reset clears the valid bits, clock and totals at once; no clearing pass.
// A stalled result output holds the sequencer; the final result may wait in the
// output register while the next command is taken.
`include "assert_macros.svh"
module retransmit_timer_table #(
  parameter int unsigned ENTRIES = rtt_pkg::ENTRIES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Command stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [15:0] packet_id, [25:16] socket_tag, [41:26] timeout_ms, [45:42] max_retries
  input  logic [47:0]  s_axis_tdata_i,
  // [2:0] command
  input  logic [2:0]   s_axis_tuser_i,
  // Result stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [15:0] packet_id_out, [25:16] socket_out, [29:26] retry_count, [31:30] status,
  // [37:32] affected, [43:38] pending_count, [75:44] total_retransmits,
  // [107:76] total_dropped
  output logic [111:0] m_axis_tdata_o,
  // [1:0] kind
  output logic [1:0]   m_axis_tuser_o,
  output logic         m_axis_tlast_o,
  // Configuration
  input  logic         psel_i,
  input  logic         penable_i,
  input  logic         pwrite_i,
  input  logic [2:0]   paddr_i,
  input  logic [31:0]  pwdata_i,
  output logic [31:0]  prdata_o,
  output logic         pready_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_POST    = 6'b000100,
    S_EMIT_RD = 6'b001000,
    S_EMIT_LD = 6'b010000,
    S_FINAL   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  localparam logic REG_EXPIRY_C = rtt_pkg::REG_EXPIRY;
  localparam logic REG_RPC_C    = rtt_pkg::REG_RPC;

  logic [5:0]  rpc_q;
  logic [31:0] expiry_q;
  logic        cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i;
  assign prdata_o = (paddr_i[2] == REG_EXPIRY_C) ? expiry_q : {26'd0, rpc_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpc_q    <= rtt_pkg::RPC_RESET;
      expiry_q <= rtt_pkg::EXPIRY_RESET;
    end else if (cfg_wr) begin
      if (paddr_i[2] == REG_RPC_C) begin
        rpc_q <= pwdata_i[5:0];
      end else begin
        expiry_q <= pwdata_i;
      end
    end
  end

  // Command latch.
  rtt_pkg::cmd_e cmd_q;
  logic [15:0]   pid_q;
  logic [9:0]    sock_q;
  logic [15:0]   tmo_q;
  logic [3:0]    maxr_q;
  logic          in_acc;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= rtt_pkg::cmd_e'(s_axis_tuser_i);
      pid_q  <= s_axis_tdata_i[15:0];
      sock_q <= s_axis_tdata_i[25:16];
      tmo_q  <= s_axis_tdata_i[41:26];
      maxr_q <= s_axis_tdata_i[45:42];
    end
  end

  // Table state held in flip-flops.
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [31:0]        now_q, now_d;
  logic [31:0]        retx_tot_q, retx_tot_d;
  logic [31:0]        drop_tot_q, drop_tot_d;
  logic [5:0]         pend_q, pend_d;

  // Scan and command progress.
  logic [CW-1:0]      idx_q, idx_d;
  logic               rsp_v_q;
  logic [IW-1:0]      rsp_idx_q;
  logic               found_q, found_d;
  logic [IW-1:0]      hit_q, hit_d;
  logic [5:0]         aff_q, aff_d;
  logic [5:0]         sent_q, sent_d;
  logic [CW-1:0]      rcnt_q, rcnt_d;
  logic [CW-1:0]      emit_q, emit_d;
  rtt_pkg::status_e   status_q, status_d;

  // Memory ports.
  logic               sm_rd_en;
  rtt_pkg::slot_ent_t sm_rdata;
  logic               sm_wr_en;
  logic [IW-1:0]      sm_wr_addr;
  rtt_pkg::slot_ent_t sm_wdata;
  logic               rb_wr_en;
  rtt_pkg::res_ent_t  rb_wdata;
  logic               rb_rd_en;
  rtt_pkg::res_ent_t  rb_rdata;

  rtt_slot_mem #(.ENTRIES(ENTRIES)) u_slot_mem (
    .clk_i     (clk_i),
    .rd_en_i   (sm_rd_en),
    .rd_addr_i (idx_q[IW-1:0]),
    .rd_data_o (sm_rdata),
    .wr_en_i   (sm_wr_en),
    .wr_addr_i (sm_wr_addr),
    .wr_data_i (sm_wdata)
  );

  rtt_result_buf #(.ENTRIES(ENTRIES)) u_result_buf (
    .clk_i     (clk_i),
    .wr_en_i   (rb_wr_en),
    .wr_addr_i (rcnt_q[IW-1:0]),
    .wr_data_i (rb_wdata),
    .rd_en_i   (rb_rd_en),
    .rd_addr_i (emit_q[IW-1:0]),
    .rd_data_o (rb_rdata)
  );

  // Lowest free slot for a new record.
  logic          free_any;
  logic [IW-1:0] free_idx;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // Output register.
  logic          m_valid_q;
  logic [111:0]  m_data_q;
  logic [1:0]    m_user_q;
  logic          m_last_q;
  logic          out_free;
  logic          out_load;
  logic          out_load_last;
  rtt_pkg::kind_e out_kind;
  logic [15:0]   out_pid;
  logic [9:0]    out_sock;
  logic [3:0]    out_retry;
  logic [1:0]    out_status;
  logic [5:0]    out_aff;

  assign out_free = !m_valid_q || m_axis_tready_i;

  // Response stage decode.
  logic        rsp_valid_slot;
  logic [31:0] age;
  logic        pid_hit;
  logic        sock_hit;
  logic        tmo_hit;
  logic        exp_hit;

  assign rsp_valid_slot = rsp_v_q && valid_q[rsp_idx_q];
  assign age            = now_q - sm_rdata.sent_time;
  assign pid_hit        = rsp_valid_slot && (sm_rdata.packet_id == pid_q);
  assign sock_hit       = rsp_valid_slot && (sm_rdata.socket == sock_q);
  assign tmo_hit        = rsp_valid_slot && (age >= {16'd0, tmo_q});
  assign exp_hit        = rsp_valid_slot && (age >= expiry_q);

  // Sequencer.
  always_comb begin
    state_d       = state_q;
    valid_d       = valid_q;
    now_d         = now_q;
    retx_tot_d    = retx_tot_q;
    drop_tot_d    = drop_tot_q;
    pend_d        = pend_q;
    idx_d         = idx_q;
    found_d       = found_q;
    hit_d         = hit_q;
    aff_d         = aff_q;
    sent_d        = sent_q;
    rcnt_d        = rcnt_q;
    emit_d        = emit_q;
    status_d      = status_q;
    sm_rd_en      = 1'b0;
    sm_wr_en      = 1'b0;
    sm_wr_addr    = rsp_idx_q;
    sm_wdata      = sm_rdata;
    rb_wr_en      = 1'b0;
    rb_wdata      = '{kind: rtt_pkg::KIND_DROP, packet_id: sm_rdata.packet_id,
                      socket: sm_rdata.socket, retries: sm_rdata.retries};
    rb_rd_en      = 1'b0;
    out_load      = 1'b0;
    out_load_last = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          idx_d    = '0;
          found_d  = 1'b0;
          aff_d    = '0;
          sent_d   = '0;
          rcnt_d   = '0;
          emit_d   = '0;
          status_d = rtt_pkg::ST_OK;
          state_d  = S_SCAN;
          unique case (rtt_pkg::cmd_e'(s_axis_tuser_i))
            rtt_pkg::CMD_TICK: begin
              now_d   = now_q + 32'd1;
              state_d = S_EMIT_RD;
            end
            rtt_pkg::CMD_CLEAR: begin
              aff_d      = pend_q;
              valid_d    = '0;
              pend_d     = '0;
              retx_tot_d = '0;
              drop_tot_d = '0;
              state_d    = S_EMIT_RD;
            end
            rtt_pkg::CMD_UNUSED: begin
              state_d = S_EMIT_RD;
            end
            default: begin
              state_d = S_SCAN;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue one slot read per cycle.
        if (idx_q < CW'(ENTRIES)) begin
          sm_rd_en = 1'b1;
          idx_d    = idx_q + CW'(1);
        end else if (!rsp_v_q) begin
          state_d = S_POST;
        end
        // Handle the slot read in the previous cycle.
        unique case (cmd_q)
          rtt_pkg::CMD_RECORD: begin
            if (pid_hit && !found_q) begin
              found_d = 1'b1;
              hit_d   = rsp_idx_q;
            end
          end
          rtt_pkg::CMD_CONF_ID: begin
            if (pid_hit && !found_q) begin
              found_d            = 1'b1;
              valid_d[rsp_idx_q] = 1'b0;
              pend_d             = pend_q - 6'd1;
              aff_d              = 6'd1;
            end
          end
          rtt_pkg::CMD_CONF_SOCK: begin
            if (sock_hit) begin
              valid_d[rsp_idx_q] = 1'b0;
              pend_d             = pend_q - 6'd1;
              aff_d              = aff_q + 6'd1;
            end
          end
          rtt_pkg::CMD_CHECK: begin
            if (tmo_hit && (sent_q < rpc_q)) begin
              aff_d    = aff_q + 6'd1;
              rb_wr_en = 1'b1;
              rcnt_d   = rcnt_q + CW'(1);
              if (sm_rdata.retries >= maxr_q) begin
                valid_d[rsp_idx_q] = 1'b0;
                pend_d             = pend_q - 6'd1;
                drop_tot_d         = drop_tot_q + 32'd1;
              end else begin
                sm_wr_en           = 1'b1;
                sm_wdata.sent_time = now_q;
                sm_wdata.retries   = sm_rdata.retries + 4'd1;
                rb_wdata.kind      = rtt_pkg::KIND_RETX;
                rb_wdata.retries   = sm_rdata.retries + 4'd1;
                retx_tot_d         = retx_tot_q + 32'd1;
                sent_d             = sent_q + 6'd1;
              end
            end
          end
          rtt_pkg::CMD_CLEANUP: begin
            if (exp_hit) begin
              aff_d              = aff_q + 6'd1;
              rb_wr_en           = 1'b1;
              rcnt_d             = rcnt_q + CW'(1);
              valid_d[rsp_idx_q] = 1'b0;
              pend_d             = pend_q - 6'd1;
              drop_tot_d         = drop_tot_q + 32'd1;
            end
          end
          default: begin
          end
        endcase
      end

      S_POST: begin
        // Record writes the matching or the lowest free slot, or reports a full table; confirm by id reports a miss.
        state_d  = S_EMIT_RD;
        sm_wdata = '{packet_id: pid_q, socket: sock_q, sent_time: now_q, retries: 4'd0};
        if (cmd_q == rtt_pkg::CMD_RECORD) begin
          if (found_q) begin
            sm_wr_en   = 1'b1;
            sm_wr_addr = hit_q;
          end else if (free_any) begin
            sm_wr_en          = 1'b1;
            sm_wr_addr        = free_idx;
            valid_d[free_idx] = 1'b1;
            pend_d            = pend_q + 6'd1;
          end else begin
            status_d = rtt_pkg::ST_FULL;
          end
        end else if (cmd_q == rtt_pkg::CMD_CONF_ID && !found_q) begin
          status_d = rtt_pkg::ST_NOT_FOUND;
        end
      end

      S_EMIT_RD: begin
        if (emit_q < rcnt_q) begin
          rb_rd_en = 1'b1;
          state_d  = S_EMIT_LD;
        end else begin
          state_d = S_FINAL;
        end
      end

      S_EMIT_LD: begin
        if (out_free) begin
          out_load = 1'b1;
          emit_d   = emit_q + CW'(1);
          state_d  = S_EMIT_RD;
        end
      end

      S_FINAL: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_load_last = 1'b1;
          state_d       = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Fields of the beat loaded into the output register.
  always_comb begin
    if (out_load_last) begin
      out_kind   = (cmd_q == rtt_pkg::CMD_CHECK) ? rtt_pkg::KIND_SUMMARY
                                                 : rtt_pkg::KIND_STATUS;
      out_pid    = '0;
      out_sock   = '0;
      out_retry  = '0;
      out_status = status_q;
      out_aff    = aff_q;
    end else begin
      out_kind   = rb_rdata.kind;
      out_pid    = rb_rdata.packet_id;
      out_sock   = rb_rdata.socket;
      out_retry  = rb_rdata.retries;
      out_status = rtt_pkg::ST_OK;
      out_aff    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      valid_q    <= '0;
      now_q      <= '0;
      retx_tot_q <= '0;
      drop_tot_q <= '0;
      pend_q     <= '0;
      idx_q      <= '0;
      rsp_v_q    <= 1'b0;
      rcnt_q     <= '0;
      emit_q     <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      now_q      <= now_d;
      retx_tot_q <= retx_tot_d;
      drop_tot_q <= drop_tot_d;
      pend_q     <= pend_d;
      idx_q      <= idx_d;
      rsp_v_q    <= sm_rd_en;
      rcnt_q     <= rcnt_d;
      emit_q     <= emit_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Per-command registers without reset.
  always_ff @(posedge clk_i) begin
    rsp_idx_q <= idx_q[IW-1:0];
    found_q   <= found_d;
    hit_q     <= hit_d;
    aff_q     <= aff_d;
    sent_q    <= sent_d;
    status_q  <= status_d;
    if (out_load) begin
      m_data_q <= {4'd0, drop_tot_d, retx_tot_d, pend_d, out_aff, out_status,
                   out_retry, out_sock, out_pid};
      m_user_q <= out_kind;
      m_last_q <= out_load_last;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

  // Checks on the sequencer.
  `RTT_ASSERT_HOLDS(a_pend_count, pend_q == 6'($countones(valid_q)), "pending count mismatch")
  `RTT_ASSERT_IMPLIES(a_idle_no_rsp, s_axis_tready_o, !rsp_v_q, "slot read open while idle")
  `RTT_ASSERT_HOLDS(a_rcnt_range, rcnt_q <= CW'(ENTRIES), "result buffer overrun")
  `RTT_ASSERT_IMPLIES(a_emit_order, state_q == S_EMIT_LD, emit_q < rcnt_q, "emit past buffer")

endmodule

// ----- dv/tb_retransmit_timer_table.sv -----
// Self-checking testbench for the retransmit timer table: directed and random commands.
module tb_retransmit_timer_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = rtt_pkg::ENTRIES_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  // One expected result beat.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] pid;
    logic [9:0]  sock;
    logic [3:0]  retry;
    logic [1:0]  status;
    logic [5:0]  affected;
    logic [5:0]  pending;
    logic [31:0] retx_total;
    logic [31:0] drop_total;
    logic        last;
  } beat_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [47:0]  s_axis_tdata_i = '0;
  logic [2:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [111:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;
  logic         m_axis_tlast_o;
  logic         psel_i = 1'b0;
  logic         penable_i = 1'b0;
  logic         pwrite_i = 1'b0;
  logic [2:0]   paddr_i = '0;
  logic [31:0]  pwdata_i = '0;
  logic [31:0]  prdata_o;
  logic         pready_o;

  retransmit_timer_table u_top (.*);

  always #4 clk_i = ~clk_i;

  // Shadow copy of the table.
  logic        shadow_valid [NSLOT];
  logic [15:0] shadow_pid [NSLOT];
  logic [9:0]  shadow_sock [NSLOT];
  logic [31:0] shadow_sent [NSLOT];
  logic [3:0]  shadow_retries [NSLOT];
  logic [31:0] clock_ms, retx_sum, drop_sum;
  logic [5:0]  cfg_rpc;
  logic [31:0] cfg_expiry;

  beat_t expected_beats[$];
  int    errors, cmds_sent, beats_seen, idle_cycles;
  bit    no_idle;
  int    cmd_hist [8];

  function automatic int count_pending();
    int n;
    n = 0;
    for (int i = 0; i < NSLOT; i++) if (shadow_valid[i]) n++;
    return n;
  endfunction

  function automatic beat_t entry_beat(rtt_pkg::kind_e k, int i);
    beat_t b;
    b = '0;
    b.kind = k;
    b.pid = shadow_pid[i];
    b.sock = shadow_sock[i];
    b.retry = shadow_retries[i];
    return b;
  endfunction

  // Work out the result beats of one command and update the shadow table.
  task automatic predict_command(rtt_pkg::cmd_e cmd, logic [15:0] pid, logic [9:0] sock,
                                 logic [15:0] tmo, logic [3:0] maxr);
    beat_t beats[$];
    beat_t fin;
    int slot, sent, pend;
    fin = '0;
    slot = -1;
    sent = 0;
    case (cmd)
      rtt_pkg::CMD_TICK: begin
        clock_ms++;
      end
      rtt_pkg::CMD_RECORD: begin
        for (int i = 0; i < NSLOT && slot < 0; i++)
          if (shadow_valid[i] && shadow_pid[i] == pid) slot = i;
        for (int i = 0; i < NSLOT && slot < 0; i++)
          if (!shadow_valid[i]) slot = i;
        if (slot < 0) begin
          fin.status = rtt_pkg::ST_FULL;
        end else begin
          shadow_valid[slot] = 1'b1;
          shadow_pid[slot] = pid;
          shadow_sock[slot] = sock;
          shadow_sent[slot] = clock_ms;
          shadow_retries[slot] = '0;
        end
      end
      rtt_pkg::CMD_CONF_ID: begin
        fin.status = rtt_pkg::ST_NOT_FOUND;
        for (int i = 0; i < NSLOT && fin.affected == 0; i++)
          if (shadow_valid[i] && shadow_pid[i] == pid) begin
            shadow_valid[i] = 1'b0;
            fin.status = rtt_pkg::ST_OK;
            fin.affected = 6'd1;
          end
      end
      rtt_pkg::CMD_CONF_SOCK: begin
        for (int i = 0; i < NSLOT; i++)
          if (shadow_valid[i] && shadow_sock[i] == sock) begin
            shadow_valid[i] = 1'b0;
            fin.affected++;
          end
      end
      rtt_pkg::CMD_CHECK: begin
        fin.kind = rtt_pkg::KIND_SUMMARY;
        for (int i = 0; i < NSLOT && sent < cfg_rpc; i++) begin
          if (shadow_valid[i] && (clock_ms - shadow_sent[i]) >= {16'd0, tmo}) begin
            if (shadow_retries[i] >= maxr) begin
              beats = {beats, entry_beat(rtt_pkg::KIND_DROP, i)};
              shadow_valid[i] = 1'b0;
              drop_sum++;
            end else begin
              shadow_retries[i]++;
              shadow_sent[i] = clock_ms;
              retx_sum++;
              sent++;
              beats = {beats, entry_beat(rtt_pkg::KIND_RETX, i)};
            end
            fin.affected++;
          end
        end
      end
      rtt_pkg::CMD_CLEANUP: begin
        for (int i = 0; i < NSLOT; i++)
          if (shadow_valid[i] && (clock_ms - shadow_sent[i]) >= cfg_expiry) begin
            beats = {beats, entry_beat(rtt_pkg::KIND_DROP, i)};
            shadow_valid[i] = 1'b0;
            drop_sum++;
            fin.affected++;
          end
      end
      rtt_pkg::CMD_CLEAR: begin
        fin.affected = 6'(count_pending());
        for (int i = 0; i < NSLOT; i++) shadow_valid[i] = 1'b0;
        retx_sum = '0;
        drop_sum = '0;
      end
      default: ;
    endcase
    beats = {beats, fin};
    pend = count_pending();
    foreach (beats[j]) begin
      beats[j].pending = 6'(pend);
      beats[j].retx_total = retx_sum;
      beats[j].drop_total = drop_sum;
      beats[j].last = (j == beats.size() - 1);
      expected_beats = {expected_beats, beats[j]};
    end
  endtask

  // Send one command beat, idling at random first.
  task automatic send_command(rtt_pkg::cmd_e cmd, logic [15:0] pid, logic [9:0] sock,
                              logic [15:0] tmo, logic [3:0] maxr);
    while (!no_idle && $urandom_range(99) < 19) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= cmd;
    s_axis_tdata_i <= {2'b00, maxr, tmo, sock, pid};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_command(cmd, pid, sock, tmo, maxr);
    cmds_sent++;
    cmd_hist[cmd]++;
  endtask

  // Write a register once the table is idle.
  task automatic write_register(int idx, logic [31:0] value);
    s_axis_tvalid_i <= 1'b0;
    wait (expected_beats.size() == 0);
    repeat (40) @(posedge clk_i);
    psel_i <= 1'b1;
    pwrite_i <= 1'b1;
    paddr_i <= 3'(4 * idx);
    pwdata_i <= value;
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    psel_i <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i <= 1'b0;
    if (idx == rtt_pkg::REG_RPC) cfg_rpc = value[5:0];
    else cfg_expiry = value;
  endtask

  task automatic test_directed();
    send_command(rtt_pkg::CMD_CONF_ID, 16'h1234, 10'd0, 16'd0, 4'd0);
    send_command(rtt_pkg::CMD_RECORD, 16'hFFFF, 10'h3FF, 16'd0, 4'd0);
    send_command(rtt_pkg::CMD_RECORD, 16'h0000, 10'h000, 16'd0, 4'd0);
    send_command(rtt_pkg::CMD_RECORD, 16'hFFFF, 10'h155, 16'd0, 4'd0);
    send_command(rtt_pkg::CMD_TICK, 16'd0, 10'd0, 16'd0, 4'd0);
    send_command(rtt_pkg::CMD_CHECK, 16'd0, 10'd0, 16'hFFFF, 4'hF);
    send_command(rtt_pkg::CMD_CHECK, 16'd0, 10'd0, 16'd0, 4'hF);
    send_command(rtt_pkg::CMD_CHECK, 16'd0, 10'd0, 16'd0, 4'd1);
    send_command(rtt_pkg::CMD_CONF_SOCK, 16'd0, 10'h155, 16'd0, 4'd0);
    send_command(rtt_pkg::CMD_CONF_ID, 16'h0000, 10'd0, 16'd0, 4'd0);
    send_command(rtt_pkg::CMD_UNUSED, 16'hFFFF, 10'h3FF, 16'hFFFF, 4'hF);
    // Fill the table, then one more record is refused.
    for (int i = 0; i <= NSLOT; i++)
      send_command(rtt_pkg::CMD_RECORD, 16'(i), 10'd7, 16'd0, 4'd0);
    send_command(rtt_pkg::CMD_CLEANUP, 16'd0, 10'd0, 16'd0, 4'd0);
    send_command(rtt_pkg::CMD_CLEAR, 16'd0, 10'd0, 16'd0, 4'd0);
  endtask

  task automatic test_limits();
    write_register(rtt_pkg::REG_RPC, 32'd63);
    write_register(rtt_pkg::REG_EXPIRY, 32'd1);
    for (int i = 0; i < 12; i++)
      send_command(rtt_pkg::CMD_RECORD, 16'(i), 10'(i), 16'd0, 4'd0);
    send_command(rtt_pkg::CMD_TICK, 16'd0, 10'd0, 16'd0, 4'd0);
    send_command(rtt_pkg::CMD_CHECK, 16'd0, 10'd0, 16'd0, 4'd2);
    send_command(rtt_pkg::CMD_CLEANUP, 16'd0, 10'd0, 16'd0, 4'd0);
    write_register(rtt_pkg::REG_RPC, 32'd0);
    send_command(rtt_pkg::CMD_RECORD, 16'd9, 10'd9, 16'd0, 4'd0);
    send_command(rtt_pkg::CMD_CHECK, 16'd0, 10'd0, 16'd0, 4'd5);
    write_register(rtt_pkg::REG_RPC, 32'd1);
    write_register(rtt_pkg::REG_EXPIRY, 32'hFFFF_FFFF);
    send_command(rtt_pkg::CMD_CHECK, 16'd0, 10'd0, 16'd0, 4'd5);
    send_command(rtt_pkg::CMD_CLEANUP, 16'd0, 10'd0, 16'd0, 4'd0);
  endtask

  // Random traffic on a small id and socket space so that hits are frequent.
  task automatic test_random(int n, logic [31:0] expiry, logic [5:0] rpc);
    int sel;
    rtt_pkg::cmd_e cmd;
    logic [15:0] pid;
    logic [9:0] sock;
    write_register(rtt_pkg::REG_RPC, 32'(rpc));
    write_register(rtt_pkg::REG_EXPIRY, expiry);
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 30) cmd = rtt_pkg::CMD_TICK;
      else if (sel < 55) cmd = rtt_pkg::CMD_RECORD;
      else if (sel < 65) cmd = rtt_pkg::CMD_CONF_ID;
      else if (sel < 70) cmd = rtt_pkg::CMD_CONF_SOCK;
      else if (sel < 88) cmd = rtt_pkg::CMD_CHECK;
      else if (sel < 95) cmd = rtt_pkg::CMD_CLEANUP;
      else if (sel < 97) cmd = rtt_pkg::CMD_CLEAR;
      else cmd = rtt_pkg::CMD_UNUSED;
      pid = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(40));
      sock = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(5));
      send_command(cmd, pid, sock,
                   ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(6)),
                   4'($urandom));
    end
  endtask

  // Result side: random stalls and field checks.
  always @(posedge clk_i) begin
    beat_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = {m_axis_tuser_o, m_axis_tdata_o[15:0], m_axis_tdata_o[25:16],
               m_axis_tdata_o[29:26], m_axis_tdata_o[31:30], m_axis_tdata_o[37:32],
               m_axis_tdata_o[43:38], m_axis_tdata_o[75:44], m_axis_tdata_o[107:76],
               m_axis_tlast_o};
        beats_seen++;
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected result beat, actual %h", $time, got);
          errors++;
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch, expected %h, actual %h", $time, want, got);
            errors++;
          end
        end
      end
      m_axis_tready_i <= no_idle || ($urandom_range(99) >= 19);
    end
  end

  // Watchdog over cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cmds_sent = 0;
    beats_seen = 0;
    idle_cycles = 0;
    no_idle = 0;
    for (int i = 0; i < NSLOT; i++) shadow_valid[i] = 1'b0;
    for (int i = 0; i < 8; i++) cmd_hist[i] = 0;
    clock_ms = '0;
    retx_sum = '0;
    drop_sum = '0;
    cfg_rpc = rtt_pkg::RPC_RESET;
    cfg_expiry = rtt_pkg::EXPIRY_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_limits();
    test_random(120, 32'd5, 6'd3);
    no_idle = 1;
    test_random(80, 32'd12, 6'd63);
    no_idle = 0;
    test_random(120, 32'd31000, 6'd5);
    s_axis_tvalid_i <= 1'b0;
    wait (expected_beats.size() == 0);
    repeat (60) @(posedge clk_i);
    $display("Covered %0d commands (tick %0d, record %0d, check %0d, cleanup %0d) and",
             cmds_sent, cmd_hist[rtt_pkg::CMD_TICK], cmd_hist[rtt_pkg::CMD_RECORD],
             cmd_hist[rtt_pkg::CMD_CHECK], cmd_hist[rtt_pkg::CMD_CLEANUP]);
    $display("%0d result beats under random stalls, with %0d mismatches.", beats_seen, errors);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+src
src/rtt_pkg.sv
src/rtt_slot_mem.sv
src/rtt_result_buf.sv
src/retransmit_timer_table.sv
dv/tb_retransmit_timer_table.sv
